@@ rtl/prqs_pkg.sv @@
`timescale 1ns / 1ps

package prqs_pkg;

  localparam int DEFAULT_QUEUE_DEPTH = 16;

  localparam int PRIO_W    = 8;
  localparam int BURST_W   = 16;
  localparam int ID_W      = 16;
  localparam int TIME_W    = 32;
  localparam int STATUS_W  = 2;

  localparam logic OP_INSERT   = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [STATUS_W-1:0] ST_INSERTED   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DISPATCHED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd3;

  typedef struct packed {
    logic [PRIO_W-1:0]  prio;
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  arrival;
    logic [ID_W-1:0]    id;
  } entry_t;

  typedef struct packed {
    logic              ins_en;
    logic              disp_en;
    logic [PRIO_W-1:0] prio;
  } cell_cmd_t;

endpackage

@@ rtl/prqs_cell.sv @@
`timescale 1ns / 1ps

module prqs_cell #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 5
) (
  input  logic               clk,
  input  prqs_pkg::cell_cmd_t cmd,
  input  prqs_pkg::entry_t    new_ent,
  input  logic [CNT_W-1:0]   occ,
  input  prqs_pkg::entry_t    left_ent,
  input  logic               left_ge,
  input  prqs_pkg::entry_t    right_ent,
  output prqs_pkg::entry_t    ent,
  output logic               ge
);
  import prqs_pkg::*;

  localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

  entry_t ent_r;
  entry_t ent_nxt;

  // A cell at or beyond the fill level, or holding an equal or larger priority,
  // lies behind the position of a newly inserted word.
  assign ge  = (IDX >= occ) || (cmd.prio <= ent_r.prio);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.ins_en && ge) begin
      ent_nxt = left_ge ? left_ent : new_ent;
    end else if (cmd.disp_en) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule

@@ rtl/priority_ready_queue_scheduler_top.sv @@
`timescale 1ns / 1ps
// A word is accepted only in the idle state and moves the FSM to execute; the
// result strobe is registered from the execute state. busy is high for the one
// execute cycle, when the queue cells shift in parallel; no word is taken then.
// Reset (synchronous, active low) empties the queue, sets the next id to one and
// clears the clock and the totals. The receiver cannot stall the result strobe.
module priority_ready_queue_scheduler_top #(
  parameter int QUEUE_DEPTH = prqs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_func,
  input  logic [prqs_pkg::BURST_W-1:0]    in_burst_time,
  input  logic [prqs_pkg::PRIO_W-1:0]     in_priority_req,
  output logic                            out_valid,
  output logic [prqs_pkg::STATUS_W-1:0]   out_status,
  output logic [prqs_pkg::ID_W-1:0]       out_process_id,
  output logic [prqs_pkg::TIME_W-1:0]     out_waiting_time,
  output logic [prqs_pkg::TIME_W-1:0]     out_clock_after,
  output logic [prqs_pkg::TIME_W-1:0]     out_total_waiting,
  output logic [prqs_pkg::TIME_W-1:0]     out_executed_count
);
  import prqs_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic func_r;
  logic [BURST_W-1:0] burst_r;
  logic [PRIO_W-1:0]  prio_r;

  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic [ID_W-1:0]   next_id_r, next_id_nxt;
  logic [TIME_W-1:0] clock_r, clock_nxt;
  logic [TIME_W-1:0] wait_sum_r, wait_sum_nxt;
  logic [TIME_W-1:0] done_r, done_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [ID_W-1:0]     out_id_r, out_id_nxt;
  logic [TIME_W-1:0]   out_wait_r, out_wait_nxt;

  logic accept, exec, full, empty;
  logic [TIME_W-1:0] head_wait;
  cell_cmd_t cmd;
  entry_t    new_ent;
  entry_t    chain_ent [QUEUE_DEPTH];
  logic      chain_ge  [QUEUE_DEPTH];

  assign accept = start && (state_r == S_IDLE);
  assign exec   = (state_r == S_EXEC);
  assign busy   = exec;
  assign full   = (occ_r == FULL_CNT);
  assign empty  = (occ_r == '0);

  assign cmd.ins_en  = exec && (func_r == OP_INSERT) && !full;
  assign cmd.disp_en = exec && (func_r == OP_DISPATCH) && !empty;
  assign cmd.prio    = prio_r;

  assign new_ent.prio    = prio_r;
  assign new_ent.burst   = burst_r;
  assign new_ent.arrival = clock_r;
  assign new_ent.id      = next_id_r;

  assign head_wait = clock_r - chain_ent[0].arrival;

  for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
    entry_t left_ent, right_ent;
    logic   left_ge;
    if (gi == 0) begin : g_first
      assign left_ent = new_ent;
      assign left_ge  = 1'b0;
    end else begin : g_mid
      assign left_ent = chain_ent[gi-1];
      assign left_ge  = chain_ge[gi-1];
    end
    if (gi == QUEUE_DEPTH - 1) begin : g_last
      assign right_ent = chain_ent[gi];
    end else begin : g_inner
      assign right_ent = chain_ent[gi+1];
    end
    prqs_cell #(
      .CELL_IDX(gi),
      .CNT_W   (CNT_W)
    ) u_cell (
      .clk      (clk),
      .cmd      (cmd),
      .new_ent  (new_ent),
      .occ      (occ_r),
      .left_ent (left_ent),
      .left_ge  (left_ge),
      .right_ent(right_ent),
      .ent      (chain_ent[gi]),
      .ge       (chain_ge[gi])
    );
  end

  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    next_id_nxt    = next_id_r;
    clock_nxt      = clock_r;
    wait_sum_nxt   = wait_sum_r;
    done_nxt       = done_r;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_wait_nxt   = out_wait_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt    = S_IDLE;
        out_id_nxt   = '0;
        out_wait_nxt = '0;
        if (func_r == OP_INSERT) begin
          if (full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_INSERTED;
            out_id_nxt     = next_id_r;
            occ_nxt        = occ_r + 1'b1;
            next_id_nxt    = next_id_r + 1'b1;
          end
        end else begin
          if (empty) begin
            out_status_nxt = ST_EMPTY;
          end else begin
            out_status_nxt = ST_DISPATCHED;
            out_id_nxt     = chain_ent[0].id;
            out_wait_nxt   = head_wait;
            occ_nxt        = occ_r - 1'b1;
            wait_sum_nxt   = wait_sum_r + head_wait;
            clock_nxt      = clock_r + TIME_W'(chain_ent[0].burst);
            done_nxt       = done_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      next_id_r   <= ID_W'(1);
      clock_r     <= '0;
      wait_sum_r  <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      next_id_r   <= next_id_nxt;
      clock_r     <= clock_nxt;
      wait_sum_r  <= wait_sum_nxt;
      done_r      <= done_nxt;
      out_valid_r <= exec;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      burst_r <= in_burst_time;
      prio_r  <= in_priority_req;
    end
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_wait_r   <= out_wait_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_process_id     = out_id_r;
  assign out_waiting_time   = out_wait_r;
  assign out_clock_after    = clock_r;
  assign out_total_waiting  = wait_sum_r;
  assign out_executed_count = done_r;

endmodule

@@ verif/prqs_tb_pkg.sv @@
`timescale 1ns / 1ps

package prqs_tb_pkg;

  localparam logic FUNC_INSERT   = prqs_pkg::OP_INSERT;
  localparam logic FUNC_DISPATCH = prqs_pkg::OP_DISPATCH;

endpackage

@@ verif/prqs_checker.sv @@
`timescale 1ns / 1ps

module prqs_checker #(
  parameter int QUEUE_DEPTH = prqs_pkg::DEFAULT_QUEUE_DEPTH
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  logic                          in_func,
  input  logic [prqs_pkg::BURST_W-1:0]  in_burst_time,
  input  logic [prqs_pkg::PRIO_W-1:0]   in_priority_req,
  input  logic                          out_valid,
  input  logic [prqs_pkg::STATUS_W-1:0] out_status,
  input  logic [prqs_pkg::ID_W-1:0]     out_process_id,
  input  logic [prqs_pkg::TIME_W-1:0]   out_waiting_time,
  input  logic [prqs_pkg::TIME_W-1:0]   out_clock_after,
  input  logic [prqs_pkg::TIME_W-1:0]   out_total_waiting,
  input  logic [prqs_pkg::TIME_W-1:0]   out_executed_count,
  output int                            fail_count,
  output int                            pending
);
  import prqs_pkg::*;
  import prqs_tb_pkg::*;

  localparam int PRINT_CAP = 100;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     pid;
    logic [TIME_W-1:0]   wait_cycles;
    logic [TIME_W-1:0]   clk_after;
    logic [TIME_W-1:0]   wait_total;
    logic [TIME_W-1:0]   done_n;
  } sched_result_t;

  sched_result_t     sched_results_q[$];

  logic [PRIO_W-1:0]  job_prio[QUEUE_DEPTH];
  logic [BURST_W-1:0] job_burst[QUEUE_DEPTH];
  logic [TIME_W-1:0]  job_arrival[QUEUE_DEPTH];
  logic [ID_W-1:0]    job_id[QUEUE_DEPTH];
  int                 job_count;
  logic [ID_W-1:0]    next_pid;
  logic [TIME_W-1:0]  sched_now;
  logic [TIME_W-1:0]  wait_sum;
  logic [TIME_W-1:0]  jobs_done;

  task automatic report_mismatch(input string field, input logic [TIME_W-1:0] got,
                                 input logic [TIME_W-1:0] want);
    if (fail_count < PRINT_CAP) begin
      $display("%0t ns: result word mismatch on %s: got %0h, expected %0h",
               $time, field, got, want);
    end
    fail_count++;
  endtask

  task automatic schedule_word(input logic func, input logic [BURST_W-1:0] burst,
                               input logic [PRIO_W-1:0] prio);
    sched_result_t      r;
    int                 pos;
    logic [BURST_W-1:0] head_burst;
    r = '{default: '0};
    if (func == FUNC_INSERT) begin
      if (job_count >= QUEUE_DEPTH) begin
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < job_count && prio > job_prio[pos]) pos++;
        for (int k = job_count; k > pos; k--) begin
          job_prio[k]    = job_prio[k-1];
          job_burst[k]   = job_burst[k-1];
          job_arrival[k] = job_arrival[k-1];
          job_id[k]      = job_id[k-1];
        end
        job_prio[pos]    = prio;
        job_burst[pos]   = burst;
        job_arrival[pos] = sched_now;
        job_id[pos]      = next_pid;
        job_count++;
        r.status = ST_INSERTED;
        r.pid    = next_pid;
        next_pid = next_pid + 1'b1;
      end
    end else if (job_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      r.status      = ST_DISPATCHED;
      r.pid         = job_id[0];
      r.wait_cycles = sched_now - job_arrival[0];
      head_burst    = job_burst[0];
      for (int k = 1; k < job_count; k++) begin
        job_prio[k-1]    = job_prio[k];
        job_burst[k-1]   = job_burst[k];
        job_arrival[k-1] = job_arrival[k];
        job_id[k-1]      = job_id[k];
      end
      job_count--;
      wait_sum  = wait_sum + r.wait_cycles;
      sched_now = sched_now + TIME_W'(head_burst);
      jobs_done = jobs_done + 1'b1;
    end
    r.clk_after  = sched_now;
    r.wait_total = wait_sum;
    r.done_n     = jobs_done;
    sched_results_q.push_back(r);
  endtask

  task automatic check_result_word();
    sched_result_t w;
    if (sched_results_q.size() == 0) begin
      report_mismatch("unexpected word", TIME_W'(out_status), '0);
      return;
    end
    w = sched_results_q.pop_front();
    if (out_status !== w.status)
      report_mismatch("status", TIME_W'(out_status), TIME_W'(w.status));
    if (out_process_id !== w.pid)
      report_mismatch("process_id", TIME_W'(out_process_id), TIME_W'(w.pid));
    if (out_waiting_time !== w.wait_cycles)
      report_mismatch("waiting_time", out_waiting_time, w.wait_cycles);
    if (out_clock_after !== w.clk_after)
      report_mismatch("clock_after", out_clock_after, w.clk_after);
    if (out_total_waiting !== w.wait_total)
      report_mismatch("total_waiting", out_total_waiting, w.wait_total);
    if (out_executed_count !== w.done_n)
      report_mismatch("executed_count", out_executed_count, w.done_n);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      sched_results_q.delete();
      job_count = 0;
      next_pid  = ID_W'(1);
      sched_now = '0;
      wait_sum  = '0;
      jobs_done = '0;
    end else begin
      if (start && !busy) schedule_word(in_func, in_burst_time, in_priority_req);
      if (out_valid) check_result_word();
    end
    pending <= sched_results_q.size();
  end

endmodule

@@ verif/tb_priority_ready_queue_scheduler_top.sv @@
`timescale 1ns / 1ps

module tb_priority_ready_queue_scheduler_top;
  import prqs_pkg::*;
  import prqs_tb_pkg::*;

  localparam int QD          = DEFAULT_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int FILL_ROUNDS = 4;
  localparam int RANDOM_WORDS = 1000;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_func = FUNC_INSERT;
  logic [BURST_W-1:0]   in_burst_time = '0;
  logic [PRIO_W-1:0]    in_priority_req = '0;
  logic                 out_valid;
  logic [STATUS_W-1:0]  out_status;
  logic [ID_W-1:0]      out_process_id;
  logic [TIME_W-1:0]    out_waiting_time;
  logic [TIME_W-1:0]    out_clock_after;
  logic [TIME_W-1:0]    out_total_waiting;
  logic [TIME_W-1:0]    out_executed_count;

  int fail_count;
  int pending;
  int cycle_n = 0;
  bit no_gaps = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  priority_ready_queue_scheduler_top #(.QUEUE_DEPTH(QD)) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_burst_time      (in_burst_time),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_process_id     (out_process_id),
    .out_waiting_time   (out_waiting_time),
    .out_clock_after    (out_clock_after),
    .out_total_waiting  (out_total_waiting),
    .out_executed_count (out_executed_count)
  );

  prqs_checker #(.QUEUE_DEPTH(QD)) u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_func            (in_func),
    .in_burst_time      (in_burst_time),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_process_id     (out_process_id),
    .out_waiting_time   (out_waiting_time),
    .out_clock_after    (out_clock_after),
    .out_total_waiting  (out_total_waiting),
    .out_executed_count (out_executed_count),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  always @(posedge clk) begin
    cycle_n <= cycle_n + 1;
    if (cycle_n >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic pause_sender();
    if (!no_gaps && $urandom_range(99) < 6) begin
      start           <= 1'b0;
      in_func         <= 1'($urandom_range(1));
      in_burst_time   <= BURST_W'($urandom);
      in_priority_req <= PRIO_W'($urandom);
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
  endtask

  task automatic send_word(input logic func, input logic [BURST_W-1:0] burst,
                           input logic [PRIO_W-1:0] prio);
    pause_sender();
    start           <= 1'b1;
    in_func         <= func;
    in_burst_time   <= burst;
    in_priority_req <= prio;
    do @(posedge clk); while (busy);
  endtask

  function automatic logic [BURST_W-1:0] pick_burst();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return BURST_W'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    int insert_pct;
    bit narrow_prio;
    logic [PRIO_W-1:0] prio;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty queue, field extremes, ties at equal priority, draining.
    send_word(FUNC_DISPATCH, '0, '0);
    send_word(FUNC_INSERT, '0, '0);
    send_word(FUNC_INSERT, '1, '1);
    send_word(FUNC_INSERT, 16'h1234, 8'h80);
    send_word(FUNC_INSERT, 16'h4321, 8'h80);
    send_word(FUNC_INSERT, 16'h0001, 8'h00);
    send_word(FUNC_INSERT, 16'hAAAA, 8'h55);
    send_word(FUNC_INSERT, 16'h5555, 8'hAA);
    repeat (7) send_word(FUNC_DISPATCH, '1, '1);
    send_word(FUNC_DISPATCH, '0, '0);

    // Fill past full and drain past empty with the longest bursts, back to back.
    no_gaps = 1'b1;
    for (int r = 0; r < FILL_ROUNDS; r++) begin
      repeat (QD + 1) send_word(FUNC_INSERT, '1, PRIO_W'($urandom));
      repeat (QD + 1) send_word(FUNC_DISPATCH, BURST_W'($urandom), PRIO_W'($urandom));
    end
    no_gaps = 1'b0;

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      case ($urandom_range(2))
        0:       insert_pct = 85;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      narrow_prio = ($urandom_range(1) == 1);
      repeat (50) begin
        prio = narrow_prio ? PRIO_W'($urandom_range(3)) : PRIO_W'($urandom);
        if ($urandom_range(99) < insert_pct)
          send_word(FUNC_INSERT, pick_burst(), prio);
        else
          send_word(FUNC_DISPATCH, BURST_W'($urandom), PRIO_W'($urandom));
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    for (int w = 0; w < 1000 && pending != 0; w++) @(posedge clk);
    repeat (5) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/prqs_pkg.sv
rtl/prqs_cell.sv
rtl/priority_ready_queue_scheduler_top.sv
verif/prqs_tb_pkg.sv
verif/prqs_checker.sv
verif/tb_priority_ready_queue_scheduler_top.sv
